>>> rtl/core/qpr_pkg.sv
package qpr_pkg;

	// Field and register widths
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 14;
	localparam int REG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 8;

	// Datapath widths: q*p products, t terms, t*conj(q) products, result terms
	localparam int P1_W  = REG_WIDTH + COORD_WIDTH;
	localparam int T_W   = P1_W + 2;
	localparam int P2_W  = T_W + REG_WIDTH;
	localparam int R_W   = P2_W + 2;
	localparam int SH    = 2 * FRAC_BITS;
	localparam int SUM_W = R_W + 1;
	localparam int SW    = SUM_W - SH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [REG_WIDTH-1:0]   rot_t;
	typedef logic signed [P1_W-1:0]        prod1_t;
	typedef logic signed [T_W-1:0]         tval_t;
	typedef logic signed [P2_W-1:0]        prod2_t;
	typedef logic signed [R_W-1:0]         rval_t;
	typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} point_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   clipped;
	} result_t;

	typedef struct packed {
		rot_t w;
		rot_t x;
		rot_t y;
		rot_t z;
	} quat_t;

	typedef struct packed {
		tval_t w;
		tval_t x;
		tval_t y;
		tval_t z;
	} tvec_t;

	typedef struct packed {
		rval_t x;
		rval_t y;
		rval_t z;
	} rvec_t;

	// Register indexes on the configuration port
	localparam cfg_idx_t CFG_ROT_W = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_ROT_X = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_ROT_Y = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_ROT_Z = cfg_idx_t'(3);

	// 1.0 in the rotation format
	localparam rot_t ROT_ONE = rot_t'(64'(1) << FRAC_BITS);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

endpackage

>>> rtl/core/qpr_fwd.sv
// First Hamilton product t = q * (0, p): products in s1, sums in s2.
module qpr_fwd (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qpr_pkg::point_t  point,
	input  qpr_pkg::quat_t   rot,
	output logic             out_valid,
	input  logic             out_ready,
	output qpr_pkg::tvec_t   t
);

	logic valid_s1, valid_s2;
	logic en_s1, en_s2;

	qpr_pkg::prod1_t wpx_s1, wpy_s1, wpz_s1;
	qpr_pkg::prod1_t xpx_s1, ypy_s1, zpz_s1;
	qpr_pkg::prod1_t ypz_s1, zpy_s1, zpx_s1, xpz_s1, xpy_s1, ypx_s1;
	qpr_pkg::tvec_t  t_s2;

	// Advance a stage when it is empty or the next one moves
	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage 1: twelve component products
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			wpx_s1 <= qpr_pkg::P1_W'(rot.w) * qpr_pkg::P1_W'(point.point_x);
			wpy_s1 <= qpr_pkg::P1_W'(rot.w) * qpr_pkg::P1_W'(point.point_y);
			wpz_s1 <= qpr_pkg::P1_W'(rot.w) * qpr_pkg::P1_W'(point.point_z);
			xpx_s1 <= qpr_pkg::P1_W'(rot.x) * qpr_pkg::P1_W'(point.point_x);
			ypy_s1 <= qpr_pkg::P1_W'(rot.y) * qpr_pkg::P1_W'(point.point_y);
			zpz_s1 <= qpr_pkg::P1_W'(rot.z) * qpr_pkg::P1_W'(point.point_z);
			ypz_s1 <= qpr_pkg::P1_W'(rot.y) * qpr_pkg::P1_W'(point.point_z);
			zpy_s1 <= qpr_pkg::P1_W'(rot.z) * qpr_pkg::P1_W'(point.point_y);
			zpx_s1 <= qpr_pkg::P1_W'(rot.z) * qpr_pkg::P1_W'(point.point_x);
			xpz_s1 <= qpr_pkg::P1_W'(rot.x) * qpr_pkg::P1_W'(point.point_z);
			xpy_s1 <= qpr_pkg::P1_W'(rot.x) * qpr_pkg::P1_W'(point.point_y);
			ypx_s1 <= qpr_pkg::P1_W'(rot.y) * qpr_pkg::P1_W'(point.point_x);
		end
	end

	// Stage 2: combine into t
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			t_s2.w <= -(qpr_pkg::T_W'(xpx_s1) + qpr_pkg::T_W'(ypy_s1)
				+ qpr_pkg::T_W'(zpz_s1));
			t_s2.x <= qpr_pkg::T_W'(wpx_s1)
				+ (qpr_pkg::T_W'(ypz_s1) - qpr_pkg::T_W'(zpy_s1));
			t_s2.y <= qpr_pkg::T_W'(wpy_s1)
				+ (qpr_pkg::T_W'(zpx_s1) - qpr_pkg::T_W'(xpz_s1));
			t_s2.z <= qpr_pkg::T_W'(wpz_s1)
				+ (qpr_pkg::T_W'(xpy_s1) - qpr_pkg::T_W'(ypx_s1));
		end
	end

	assign out_valid = valid_s2;
	assign t         = t_s2;

`ifndef SYNTH
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2)
		else $error("fwd: input blocked while a stage is empty");
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("fwd: accepted transaction missing from s1");
`endif

endmodule

>>> rtl/core/qpr_inv.sv
// Second Hamilton product r = t * conj(q), vector part only: products in s3, sums in s4.
module qpr_inv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qpr_pkg::tvec_t  t,
	input  qpr_pkg::quat_t  rot,
	output logic            out_valid,
	input  logic            out_ready,
	output qpr_pkg::rvec_t  r
);

	logic valid_s3, valid_s4;
	logic en_s3, en_s4;

	qpr_pkg::prod2_t txw_s3, xtw_s3, ytz_s3, zty_s3;
	qpr_pkg::prod2_t tyw_s3, ytw_s3, ztx_s3, xtz_s3;
	qpr_pkg::prod2_t tzw_s3, ztw_s3, xty_s3, ytx_s3;
	qpr_pkg::rvec_t  r_s4;

	// Advance a stage when it is empty or the next one moves
	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 3: twelve products of t with the quaternion
	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			txw_s3 <= qpr_pkg::P2_W'(t.x) * qpr_pkg::P2_W'(rot.w);
			xtw_s3 <= qpr_pkg::P2_W'(t.w) * qpr_pkg::P2_W'(rot.x);
			ytz_s3 <= qpr_pkg::P2_W'(t.z) * qpr_pkg::P2_W'(rot.y);
			zty_s3 <= qpr_pkg::P2_W'(t.y) * qpr_pkg::P2_W'(rot.z);
			tyw_s3 <= qpr_pkg::P2_W'(t.y) * qpr_pkg::P2_W'(rot.w);
			ytw_s3 <= qpr_pkg::P2_W'(t.w) * qpr_pkg::P2_W'(rot.y);
			ztx_s3 <= qpr_pkg::P2_W'(t.x) * qpr_pkg::P2_W'(rot.z);
			xtz_s3 <= qpr_pkg::P2_W'(t.z) * qpr_pkg::P2_W'(rot.x);
			tzw_s3 <= qpr_pkg::P2_W'(t.z) * qpr_pkg::P2_W'(rot.w);
			ztw_s3 <= qpr_pkg::P2_W'(t.w) * qpr_pkg::P2_W'(rot.z);
			xty_s3 <= qpr_pkg::P2_W'(t.y) * qpr_pkg::P2_W'(rot.x);
			ytx_s3 <= qpr_pkg::P2_W'(t.x) * qpr_pkg::P2_W'(rot.y);
		end
	end

	// Stage 4: combine into the rotated vector
	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			r_s4.x <= qpr_pkg::R_W'(txw_s3) - qpr_pkg::R_W'(xtw_s3)
				+ (qpr_pkg::R_W'(ytz_s3) - qpr_pkg::R_W'(zty_s3));
			r_s4.y <= qpr_pkg::R_W'(tyw_s3) - qpr_pkg::R_W'(ytw_s3)
				+ (qpr_pkg::R_W'(ztx_s3) - qpr_pkg::R_W'(xtz_s3));
			r_s4.z <= qpr_pkg::R_W'(tzw_s3) - qpr_pkg::R_W'(ztw_s3)
				+ (qpr_pkg::R_W'(xty_s3) - qpr_pkg::R_W'(ytx_s3));
		end
	end

	assign out_valid = valid_s4;
	assign r         = r_s4;

`ifndef SYNTH
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s3 && valid_s4)
		else $error("inv: input blocked while a stage is empty");
`endif

endmodule

>>> rtl/core/qpr_sat.sv
// Round to nearest, shift out the fraction and saturate; s5 is the output register.
module qpr_sat (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qpr_pkg::rvec_t   r,
	output logic             out_valid,
	input  logic             out_ready,
	output qpr_pkg::result_t result
);

	localparam logic [qpr_pkg::SUM_W-1:0] RND =
		qpr_pkg::SUM_W'(1) << (qpr_pkg::SH - 1);

	logic                      valid_s5;
	logic                      en_s5;
	qpr_pkg::result_t          res_s5;
	logic [qpr_pkg::COORD_WIDTH:0] fx, fy, fz;

	// Returns {clip, value} for one coordinate
	function automatic logic [qpr_pkg::COORD_WIDTH:0] finish(input qpr_pkg::rval_t v);
		logic signed [qpr_pkg::SUM_W-1:0]       sum;
		logic [qpr_pkg::SW-1:0]                 shv;
		logic [qpr_pkg::SW-qpr_pkg::COORD_WIDTH:0] top;
		logic                                   fits;
		sum  = qpr_pkg::SUM_W'(v) + RND;
		shv  = sum[qpr_pkg::SUM_W-1:qpr_pkg::SH];
		top  = shv[qpr_pkg::SW-1:qpr_pkg::COORD_WIDTH-1];
		fits = (&top) || !(|top);
		if (fits) begin
			finish = {1'b0, shv[qpr_pkg::COORD_WIDTH-1:0]};
		end else if (shv[qpr_pkg::SW-1]) begin
			finish = {1'b1, qpr_pkg::COORD_MIN};
		end else begin
			finish = {1'b1, qpr_pkg::COORD_MAX};
		end
	endfunction

	assign fx = finish(r.x);
	assign fy = finish(r.y);
	assign fz = finish(r.z);

	// Load the output register when empty or drained
	assign en_s5    = !valid_s5 || out_ready;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			res_s5.out_x   <= fx[qpr_pkg::COORD_WIDTH-1:0];
			res_s5.out_y   <= fy[qpr_pkg::COORD_WIDTH-1:0];
			res_s5.out_z   <= fz[qpr_pkg::COORD_WIDTH-1:0];
			res_s5.clipped <= fx[qpr_pkg::COORD_WIDTH] | fy[qpr_pkg::COORD_WIDTH]
				| fz[qpr_pkg::COORD_WIDTH];
		end
	end

	assign out_valid = valid_s5;
	assign result    = res_s5;

`ifndef SYNTH
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result.clipped |->
			result.out_x == qpr_pkg::COORD_MAX || result.out_x == qpr_pkg::COORD_MIN ||
			result.out_y == qpr_pkg::COORD_MAX || result.out_y == qpr_pkg::COORD_MIN ||
			result.out_z == qpr_pkg::COORD_MAX || result.out_z == qpr_pkg::COORD_MIN)
		else $error("sat: clipped flag without a saturated coordinate");
	a_take_fills_s5: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("sat: accepted transaction missing from output register");
`endif

endmodule

>>> rtl/core/quaternion_point_rotation.sv
// Quaternion point rotation: result = q * (0, p) * conj(q), vector part.
// Points enter on the point channel (point_valid / point_ready) and rotated,
// rounded, saturated coordinates leave on the result channel
// (result_valid / result_ready); clipped flags any saturated coordinate.
// The quaternion lives in four registers written through the cfg channel
// (cfg_index 0..3 = w, x, y, z in Q2.14; other indexes are ignored);
// cfg_ready is always high. Write them only while no transaction is in flight.
// A point accepted at one clock edge passes through five register stages
// (two multiply, two sum, one round/saturate) before it shows on the result
// channel. Throughput: one point per cycle while result_ready stays high;
// each stage takes a new transaction per clock unless the next one stalls.
// Reset clears every stage valid bit and loads the identity quaternion.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling until each holds a transaction; point_ready
// falls only when all five are occupied. Nothing is lost or repeated.
module quaternion_point_rotation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_ready,
	input  qpr_pkg::point_t   point,
	output logic              result_valid,
	input  logic              result_ready,
	output qpr_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  qpr_pkg::cfg_idx_t cfg_index,
	input  qpr_pkg::rot_t     cfg_data
);

	qpr_pkg::quat_t rot_q;
	qpr_pkg::tvec_t t;
	qpr_pkg::rvec_t r;
	logic t_valid, t_ready, r_valid, r_ready;

	assign cfg_ready = 1'b1;

	// Hold the rotation quaternion; write one component per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.w <= qpr_pkg::ROT_ONE;
			rot_q.x <= '0;
			rot_q.y <= '0;
			rot_q.z <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qpr_pkg::CFG_ROT_W: rot_q.w <= cfg_data;
				qpr_pkg::CFG_ROT_X: rot_q.x <= cfg_data;
				qpr_pkg::CFG_ROT_Y: rot_q.y <= cfg_data;
				qpr_pkg::CFG_ROT_Z: rot_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	qpr_fwd u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point_valid),
		.in_ready  (point_ready),
		.point     (point),
		.rot       (rot_q),
		.out_valid (t_valid),
		.out_ready (t_ready),
		.t         (t)
	);

	qpr_inv u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t_valid),
		.in_ready  (t_ready),
		.t         (t),
		.rot       (rot_q),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.r         (r)
	);

	qpr_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.r         (r),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.result    (result)
	);

`ifndef SYNTH
	a_cfg_w_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == qpr_pkg::CFG_ROT_W
		|=> rot_q.w == $past(cfg_data))
		else $error("top: rot_w write not applied");
`endif

endmodule

>>> tb/tb_quaternion_point_rotation.sv
`timescale 1ns / 1ps

module tb_quaternion_point_rotation;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 3;
	localparam int RESULT_LATENCY = 5;
	localparam int PHASE_POINTS   = 150;
	localparam int RAND_PHASES    = 8;
	localparam int HOLD_PHASE     = 2;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN      = 10;

	// First index that addresses no register
	localparam qpr_pkg::cfg_idx_t CFG_NO_REG =
		qpr_pkg::CFG_ROT_Z + qpr_pkg::cfg_idx_t'(1);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              point_valid = 1'b0;
	logic              point_ready;
	qpr_pkg::point_t   point = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	qpr_pkg::result_t  result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	qpr_pkg::cfg_idx_t cfg_index = qpr_pkg::CFG_ROT_W;
	qpr_pkg::rot_t     cfg_data = '0;

	qpr_pkg::point_t  pending_points[$];
	qpr_pkg::result_t rotated_expect[$];
	qpr_pkg::quat_t   rot_now = '{w: qpr_pkg::ROT_ONE, x: '0, y: '0, z: '0};

	bit point_took;
	int send_gap;
	int stall_left;
	int hold_left;
	int holds_asked;
	int holds_done;
	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;
	int fault_count;
	int points_sent;
	int results_checked;
	int cfg_writes;
	int settings_used;

	quaternion_point_rotation i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Round to nearest (ties up), drop the fraction bits, clamp to the coordinate range
	function automatic qpr_pkg::coord_t round_clamp(longint acc, inout logic clip);
		longint v;
		v = (acc + (longint'(1) <<< (qpr_pkg::SH - 1))) >>> qpr_pkg::SH;
		if (v > longint'(qpr_pkg::COORD_MAX)) begin
			v = longint'(qpr_pkg::COORD_MAX);
			clip = 1'b1;
		end else if (v < longint'(qpr_pkg::COORD_MIN)) begin
			v = longint'(qpr_pkg::COORD_MIN);
			clip = 1'b1;
		end
		return qpr_pkg::coord_t'(v);
	endfunction

	// Vector part of q * (0, p) * conj(q) under the current quaternion
	function automatic qpr_pkg::result_t rotate_point(qpr_pkg::point_t p);
		longint           w, x, y, z, px, py, pz;
		longint           tw, tx, ty, tz, rx, ry, rz;
		logic             clip;
		qpr_pkg::result_t r;
		w = rot_now.w;
		x = rot_now.x;
		y = rot_now.y;
		z = rot_now.z;
		px = p.point_x;
		py = p.point_y;
		pz = p.point_z;
		tw = -(x * px + y * py + z * pz);
		tx = w * px + (y * pz - z * py);
		ty = w * py + (z * px - x * pz);
		tz = w * pz + (x * py - y * px);
		rx = tx * w - x * tw + (y * tz - z * ty);
		ry = ty * w - y * tw + (z * tx - x * tz);
		rz = tz * w - z * tw + (x * ty - y * tx);
		clip = 1'b0;
		r.out_x = round_clamp(rx, clip);
		r.out_y = round_clamp(ry, clip);
		r.out_z = round_clamp(rz, clip);
		r.clipped = clip;
		return r;
	endfunction

	// Mostly full range, some small values, some extremes
	function automatic qpr_pkg::coord_t random_coord();
		int unsigned style;
		style = $urandom_range(0, 9);
		if (style <= 6)
			return qpr_pkg::coord_t'($urandom);
		if (style <= 8)
			return qpr_pkg::coord_t'($urandom_range(0, 1023) - 512);
		case ($urandom_range(0, 4))
			0: return qpr_pkg::COORD_MAX;
			1: return qpr_pkg::COORD_MIN;
			2: return qpr_pkg::coord_t'(0);
			3: return qpr_pkg::coord_t'(1);
			default: return qpr_pkg::coord_t'(-1);
		endcase
	endfunction

	function automatic qpr_pkg::point_t random_point();
		qpr_pkg::point_t p;
		p.point_x = random_coord();
		p.point_y = random_coord();
		p.point_z = random_coord();
		return p;
	endfunction

	function automatic real random_unit_real();
		return (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
	endfunction

	// Mostly unit quaternions; the rest raw, small or extreme
	function automatic qpr_pkg::quat_t random_rotation();
		qpr_pkg::quat_t q;
		real            a, b, c, d, len;
		int unsigned    style;
		style = $urandom_range(0, 9);
		if (style <= 5) begin
			a = random_unit_real();
			b = random_unit_real();
			c = random_unit_real();
			d = random_unit_real();
			len = $sqrt(a * a + b * b + c * c + d * d);
			if (len < 0.01) begin
				q = '{w: qpr_pkg::ROT_ONE, x: '0, y: '0, z: '0};
			end else begin
				q.w = qpr_pkg::rot_t'($rtoi(a * real'(qpr_pkg::ROT_ONE) / len));
				q.x = qpr_pkg::rot_t'($rtoi(b * real'(qpr_pkg::ROT_ONE) / len));
				q.y = qpr_pkg::rot_t'($rtoi(c * real'(qpr_pkg::ROT_ONE) / len));
				q.z = qpr_pkg::rot_t'($rtoi(d * real'(qpr_pkg::ROT_ONE) / len));
			end
		end else if (style <= 7) begin
			q = qpr_pkg::quat_t'({$urandom, $urandom});
		end else if (style == 8) begin
			q.w = qpr_pkg::rot_t'($urandom_range(0, 511) - 256);
			q.x = qpr_pkg::rot_t'($urandom_range(0, 511) - 256);
			q.y = qpr_pkg::rot_t'($urandom_range(0, 511) - 256);
			q.z = qpr_pkg::rot_t'($urandom_range(0, 511) - 256);
		end else begin
			q.w = $urandom_range(0, 1) ? qpr_pkg::ROT_ONE
				: qpr_pkg::rot_t'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
			q.x = $urandom_range(0, 1) ? qpr_pkg::rot_t'(16'h8000)
				: qpr_pkg::rot_t'(16'h7fff);
			q.y = $urandom_range(0, 1) ? qpr_pkg::rot_t'(0) : qpr_pkg::rot_t'(16'h7fff);
			q.z = $urandom_range(0, 1) ? qpr_pkg::rot_t'(16'h8000) : qpr_pkg::rot_t'(0);
		end
		return q;
	endfunction

	// Offer one register write and hold it until accepted
	task automatic write_rot_reg(qpr_pkg::cfg_idx_t idx, qpr_pkg::rot_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Load a full quaternion, optionally with a write to an unused index
	task automatic load_rotation(qpr_pkg::quat_t q, bit stray);
		write_rot_reg(qpr_pkg::CFG_ROT_W, q.w);
		write_rot_reg(qpr_pkg::CFG_ROT_X, q.x);
		write_rot_reg(qpr_pkg::CFG_ROT_Y, q.y);
		write_rot_reg(qpr_pkg::CFG_ROT_Z, q.z);
		if (stray)
			write_rot_reg(qpr_pkg::cfg_idx_t'($urandom_range(CFG_NO_REG, 255)),
				qpr_pkg::rot_t'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic push_point(int px, int py, int pz);
		pending_points.push_back('{point_x: qpr_pkg::coord_t'(px),
			point_y: qpr_pkg::coord_t'(py), point_z: qpr_pkg::coord_t'(pz)});
	endtask

	// Wait until every queued point is sent and every result is back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_points.size() != 0 || point_valid || rotated_expect.size() != 0);
	endtask

	// Point driver: hold the transaction until accepted, idle in bursts
	always @(negedge clk) begin
		if (arst_n && (!point_valid || point_took)) begin
			if (send_gap > 0) begin
				send_gap--;
				point_valid <= 1'b0;
			end else if ($urandom_range(0, 99) < send_idle_pct) begin
				send_gap = $urandom_range(0, 14);
				point_valid <= 1'b0;
			end else if (pending_points.size() != 0) begin
				point <= pending_points.pop_front();
				point_valid <= 1'b1;
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	// Result receiver: long hold on request, otherwise random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = LONG_HOLD - 1;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < recv_stall_pct) begin
				stall_left = $urandom_range(0, 14);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Monitor: track config, predict accepted points, check results, watch for hangs
	always @(posedge clk) begin
		qpr_pkg::result_t want;
		point_took = point_valid && point_ready;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_valid && cfg_ready) begin
				idle_cycles = 0;
				cfg_writes++;
				case (cfg_index)
					qpr_pkg::CFG_ROT_W: rot_now.w = cfg_data;
					qpr_pkg::CFG_ROT_X: rot_now.x = cfg_data;
					qpr_pkg::CFG_ROT_Y: rot_now.y = cfg_data;
					qpr_pkg::CFG_ROT_Z: rot_now.z = cfg_data;
					default: ;
				endcase
			end
			if (point_took) begin
				idle_cycles = 0;
				points_sent++;
				rotated_expect.push_back(rotate_point(point));
			end
			if (result_valid && result_ready) begin
				idle_cycles = 0;
				results_checked++;
				if (rotated_expect.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_SHOWN)
						$display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%0b",
							$realtime, result.out_x, result.out_y, result.out_z,
							result.clipped);
				end else begin
					want = rotated_expect.pop_front();
					if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
							result.out_z !== want.out_z || result.clipped !== want.clipped) begin
						fault_count++;
						if (fault_count <= MAX_SHOWN)
							$display({"%0t: result %0d expected x=%0d y=%0d z=%0d ",
								"clipped=%0b, got x=%0d y=%0d z=%0d clipped=%0b"},
								$realtime, results_checked, want.out_x, want.out_y,
								want.out_z, want.clipped, result.out_x, result.out_y,
								result.out_z, result.clipped);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, rotated_expect.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stimulus: directed corners first, then random phases with new quaternions
	initial begin
		int phase;
		int n;
		send_idle_pct = 20;
		recv_stall_pct = 20;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Identity from reset: coordinate extremes and alternating bit patterns
		push_point(0, 0, 0);
		push_point(32767, 32767, 32767);
		push_point(-32768, -32768, -32768);
		push_point(32767, -32768, 1);
		push_point(-1, -1, -1);
		push_point(21845, -21846, 21845);
		push_point(-21846, 21845, -21846);
		wait_drained();

		// Quarter turn about z, including a diagonal point at the coordinate maximum
		load_rotation('{w: qpr_pkg::rot_t'(11585), x: '0, y: '0,
			z: qpr_pkg::rot_t'(11585)}, 1'b0);
		push_point(1000, 0, 0);
		push_point(32767, 32767, 0);
		wait_drained();

		// Half-length scalar quaternion lands most coordinates exactly on rounding ties
		load_rotation('{w: qpr_pkg::rot_t'(8192), x: '0, y: '0, z: '0}, 1'b0);
		push_point(2, -2, 6);
		push_point(-6, 0, 1);
		wait_drained();

		// Non-unit extremes: largest and most negative quaternion
		load_rotation('{w: qpr_pkg::rot_t'(16'h7fff), x: qpr_pkg::rot_t'(16'h7fff),
			y: qpr_pkg::rot_t'(16'h7fff), z: qpr_pkg::rot_t'(16'h7fff)}, 1'b0);
		push_point(32767, -32768, 32767);
		push_point(1, 1, 1);
		wait_drained();
		load_rotation('{w: qpr_pkg::rot_t'(16'h8000), x: qpr_pkg::rot_t'(16'h8000),
			y: qpr_pkg::rot_t'(16'h8000), z: qpr_pkg::rot_t'(16'h8000)}, 1'b0);
		push_point(-32768, -32768, -32768);
		push_point(1, 0, -1);
		wait_drained();

		// Zero quaternion, then writes to unused indexes must change nothing
		load_rotation('{w: '0, x: '0, y: '0, z: '0}, 1'b0);
		write_rot_reg(CFG_NO_REG, qpr_pkg::ROT_ONE);
		write_rot_reg(qpr_pkg::cfg_idx_t'('1), qpr_pkg::rot_t'(16'h7fff));
		@(negedge clk);
		cfg_valid <= 1'b0;
		push_point(32767, -32768, 12345);
		wait_drained();

		// Random phases; the last one runs with no idling on either side
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == RAND_PHASES - 1) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else begin
				send_idle_pct = (phase % 4) * 12;
				recv_stall_pct = ((phase + 2) % 4) * 12;
			end
			load_rotation(random_rotation(), $urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_POINTS; n++)
				pending_points.push_back(random_point());
			if (phase == HOLD_PHASE)
				holds_asked++;
			wait_drained();
		end

		repeat (2 * RESULT_LATENCY) @(posedge clk);
		fault_count += rotated_expect.size();
		$display("Checked %0d of %0d rotated points under %0d quaternion settings (%0d writes),",
			results_checked, points_sent, settings_used, cfg_writes);
		$display("with rounding ties, saturation, non-unit quaternions and a long output stall.");
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> quaternion_point_rotation.f
rtl/core/qpr_pkg.sv
rtl/core/qpr_fwd.sv
rtl/core/qpr_inv.sv
rtl/core/qpr_sat.sv
rtl/core/quaternion_point_rotation.sv
tb/tb_quaternion_point_rotation.sv
